// ----- rtl/pse_pkg.sv -----
`default_nettype none

package pse_pkg;

  // stack size and field widths
  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_W     = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // serial unit step counts
  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = DATA_W + FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // q16.16 limits
  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // token commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVER    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CALC,
    S_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } arith_state_t;

  typedef struct packed {
    logic             start;
    logic [CMD_W-1:0] op;
  } arith_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] res;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pse_ram.sv -----
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/pse_arith.sv -----
`default_nettype none

module pse_arith (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pse_pkg::arith_req_t          req,
  input  wire logic [pse_pkg::DATA_W-1:0]   l_val,
  input  wire logic [pse_pkg::DATA_W-1:0]   r_val,
  output pse_pkg::arith_rsp_t               rsp
);

  import pse_pkg::*;

  arith_state_t      ast_r, ast_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic              sat_r, sat_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              neg_r, neg_nxt;
  logic              sticky_r, sticky_nxt;
  logic [DATA_W:0]   acc_r, acc_nxt;
  logic [DATA_W-1:0] lo_r, lo_nxt;
  logic [DATA_W-1:0] sh_r, sh_nxt;
  logic [DATA_W-1:0] mcand_r, mcand_nxt;
  logic              mcand_is_div_r, mcand_is_div_nxt;

  logic [DATA_W-1:0]   mag_l, mag_r;
  logic [DATA_W:0]     sum_as;
  logic [DATA_W:0]     sum_mul;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     rem_diff;
  logic                rem_ge;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   fin_mag;
  logic                fin_over;
  logic [DATA_W-1:0]   fin_lim;
  logic [DATA_W-1:0]   fin_val;

  // operand magnitudes and signed add or subtract
  always_comb begin
    mag_l = l_val[DATA_W-1] ? (~l_val + DATA_W'(1)) : l_val;
    mag_r = r_val[DATA_W-1] ? (~r_val + DATA_W'(1)) : r_val;
    if (req.op == CMD_SUB) begin
      sum_as = {l_val[DATA_W-1], l_val} - {r_val[DATA_W-1], r_val};
    end else begin
      sum_as = {l_val[DATA_W-1], l_val} + {r_val[DATA_W-1], r_val};
    end
  end

  // one multiplier bit per cycle: conditional add then shift right
  assign sum_mul = {1'b0, acc_r[DATA_W-1:0]} + (lo_r[0] ? {1'b0, mcand_r} : '0);

  // one quotient bit per cycle: restoring compare and subtract
  assign rem_sh   = {acc_r[DATA_W-1:0], sh_r[DATA_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, mcand_r};
  assign rem_diff = rem_sh - {1'b0, mcand_r};

  // final scaling, clamp and sign
  assign prod = {acc_r[DATA_W-1:0], lo_r};
  always_comb begin
    if (ast_r == A_FIN && !mcand_is_div_r) begin
      fin_mag  = prod[DATA_W+FRAC_W-1:FRAC_W];
      fin_over = |prod[2*DATA_W-1:DATA_W+FRAC_W];
    end else begin
      fin_mag  = lo_r;
      fin_over = sticky_r;
    end
    fin_lim = neg_r ? Q_MIN : Q_MAX;
    if (fin_over || fin_mag > fin_lim) begin
      fin_val = fin_lim;
    end else begin
      fin_val = fin_mag;
    end
  end

  // next state
  always_comb begin
    ast_nxt = ast_r;
    unique case (ast_r)
      A_IDLE: begin
        if (req.start && req.op == CMD_MUL) begin
          ast_nxt = A_MUL;
        end else if (req.start && req.op == CMD_DIV) begin
          ast_nxt = A_DIV;
        end
      end
      A_MUL: begin
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          ast_nxt = A_FIN;
        end
      end
      A_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          ast_nxt = A_FIN;
        end
      end
      A_FIN: ast_nxt = A_IDLE;
      default: ast_nxt = A_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    step_nxt         = step_r;
    done_nxt         = 1'b0;
    sat_nxt          = sat_r;
    res_nxt          = res_r;
    neg_nxt          = neg_r;
    sticky_nxt       = sticky_r;
    acc_nxt          = acc_r;
    lo_nxt           = lo_r;
    sh_nxt           = sh_r;
    mcand_nxt        = mcand_r;
    mcand_is_div_nxt = mcand_is_div_r;
    unique case (ast_r)
      A_IDLE: begin
        if (req.start) begin
          neg_nxt    = l_val[DATA_W-1] ^ r_val[DATA_W-1];
          step_nxt   = '0;
          acc_nxt    = '0;
          sticky_nxt = 1'b0;
          if (req.op == CMD_MUL) begin
            lo_nxt           = mag_r;
            mcand_nxt        = mag_l;
            mcand_is_div_nxt = 1'b0;
          end else if (req.op == CMD_DIV) begin
            lo_nxt           = '0;
            sh_nxt           = mag_l;
            mcand_nxt        = mag_r;
            mcand_is_div_nxt = 1'b1;
          end else begin
            // add or subtract finishes here
            done_nxt = 1'b1;
            if (sum_as[DATA_W] != sum_as[DATA_W-1]) begin
              sat_nxt = 1'b1;
              res_nxt = sum_as[DATA_W] ? Q_MIN : Q_MAX;
            end else begin
              sat_nxt = 1'b0;
              res_nxt = sum_as[DATA_W-1:0];
            end
          end
        end
      end
      A_MUL: begin
        step_nxt = step_r + STEP_W'(1);
        acc_nxt  = {1'b0, sum_mul[DATA_W:1]};
        lo_nxt   = {sum_mul[0], lo_r[DATA_W-1:1]};
      end
      A_DIV: begin
        step_nxt   = step_r + STEP_W'(1);
        acc_nxt    = rem_ge ? rem_diff : rem_sh;
        sh_nxt     = {sh_r[DATA_W-2:0], 1'b0};
        lo_nxt     = {lo_r[DATA_W-2:0], rem_ge};
        sticky_nxt = sticky_r | lo_r[DATA_W-1];
      end
      A_FIN: begin
        done_nxt = 1'b1;
        sat_nxt  = fin_over || fin_mag > fin_lim;
        res_nxt  = neg_r ? (~fin_val + DATA_W'(1)) : fin_val;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ast_r  <= A_IDLE;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      ast_r  <= ast_nxt;
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sat_r          <= sat_nxt;
    res_r          <= res_nxt;
    neg_r          <= neg_nxt;
    sticky_r       <= sticky_nxt;
    acc_r          <= acc_nxt;
    lo_r           <= lo_nxt;
    sh_r           <= sh_nxt;
    mcand_r        <= mcand_nxt;
    mcand_is_div_r <= mcand_is_div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
`default_nettype none

// Postfix evaluator on a stack of signed Q16.16 values: each request is one
// token (push, add, subtract, multiply or divide) and gives exactly one
// result with a status, the new top of stack, the depth and a saturation
// flag; an error leaves the stack untouched. Tokens are handled one at a
// time. Multiply and divide run on the shared serial unit, which retires
// one product bit or one quotient bit per cycle (32 steps for a product,
// 48 for a quotient, plus one final step). The stack lives in a small RAM
// with a registered read port, with the top entry mirrored in a register,
// so an operator needs one RAM read. A finished result sits in the output
// register while the next token is accepted.
module postfix_stack_evaluator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [pse_pkg::CMD_W-1:0]    in_command,
  input  wire logic signed [pse_pkg::DATA_W-1:0]   in_operand_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [pse_pkg::STATUS_W-1:0] out_status,
  output logic signed      [pse_pkg::DATA_W-1:0]   out_top_value,
  output logic             [pse_pkg::DEPTH_W-1:0]  out_depth,
  output logic                                     out_saturated
);

  import pse_pkg::*;

  ctrl_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   top_r, top_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [DATA_W-1:0]   opv_r;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic                sat_r, sat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_top_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic                out_sat_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic [DATA_W-1:0]   ram_rdata;
  logic [CNT_W-1:0]    cnt_less2;
  logic [ADDR_W-1:0]   addr_left;
  logic                out_free;
  logic                is_full;
  logic                is_op;
  logic                op_go;

  arith_req_t          a_req;
  arith_rsp_t          a_rsp;

  assign cnt_less2 = cnt_r - CNT_W'(2);
  assign addr_left = cnt_less2[ADDR_W-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign is_full   = cnt_r == CNT_W'(STACK_DEPTH);

  // command decode
  always_comb begin
    unique case (cmd_r) inside
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: is_op = 1'b1;
      default:                            is_op = 1'b0;
    endcase
  end
  assign op_go = is_op && cnt_r >= CNT_W'(2) && !(cmd_r == CMD_DIV && top_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: state_nxt = op_go ? S_READ : S_DONE;
      S_READ:   state_nxt = S_CALC;
      S_CALC:   if (a_rsp.done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // stack updates, ram control and arithmetic start
  always_comb begin
    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    st_nxt      = st_r;
    sat_nxt     = sat_r;
    ram_we      = 1'b0;
    ram_waddr   = addr_left;
    ram_wdata   = a_rsp.res;
    a_req.start = 1'b0;
    a_req.op    = cmd_r;
    unique case (state_r)
      S_DECODE: begin
        st_nxt  = ST_OK;
        sat_nxt = 1'b0;
        if (cmd_r == CMD_PUSH) begin
          if (is_full) begin
            st_nxt = ST_OVER;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[ADDR_W-1:0];
            ram_wdata = opv_r;
            top_nxt   = opv_r;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end
        end else if (is_op && cnt_r < CNT_W'(2)) begin
          st_nxt = ST_UNDER;
        end else if (is_op && cmd_r == CMD_DIV && top_r == '0) begin
          st_nxt = ST_DIVZERO;
        end
      end
      S_READ: begin
        a_req.start = 1'b1;
      end
      S_CALC: begin
        if (a_rsp.done) begin
          ram_we  = 1'b1;
          top_nxt = a_rsp.res;
          cnt_nxt = cnt_r - CNT_W'(1);
          sat_nxt = a_rsp.sat;
        end
      end
      default: ;
    endcase
  end

  // output register handshake
  always_comb begin
    if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = state_r == S_DONE;
    end
  end

  pse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_left),
    .rd_data (ram_rdata)
  );

  pse_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (a_req),
    .l_val (ram_rdata),
    .r_val (top_r),
    .rsp   (a_rsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    st_r  <= st_nxt;
    sat_r <= sat_nxt;
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      opv_r <= in_operand_value;
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= st_r;
      out_top_r    <= (cnt_r != '0) ? top_r : '0;
      out_depth_r  <= DEPTH_W'(cnt_r);
      out_sat_r    <= sat_r;
    end
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTH
  // the serial unit only answers while the controller waits for it
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    a_rsp.done |-> state_r == S_CALC)
    else $error("arithmetic result outside calc state");

  // a successful push grows the stack by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && cmd_r == CMD_PUSH && !is_full)
      |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not grow the stack");

  // a new result only appears after the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");

  // the stack never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- tb/pse_checker.sv -----
`timescale 1ns / 100ps

module pse_checker import pse_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic        [CMD_W-1:0]    in_command,
  input  wire logic signed [DATA_W-1:0]   in_operand_value,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic        [STATUS_W-1:0] out_status,
  input  wire logic signed [DATA_W-1:0]   out_top_value,
  input  wire logic        [DEPTH_W-1:0]  out_depth,
  input  wire logic                       out_saturated,
  input  wire logic                       end_of_run,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked,
  output int                              saturations,
  output logic             [3:0]          status_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   top_value;
    logic [DEPTH_W-1:0]  depth;
    logic                saturated;
  } token_result_t;

  localparam longint Q_HI = longint'($signed(Q_MAX));
  localparam longint Q_LO = longint'($signed(Q_MIN));

  // shadow operand stack
  logic [DATA_W-1:0] value_stack [STACK_DEPTH];
  int unsigned       stack_count;
  token_result_t     predicted_results [$];
  int                mismatches;
  int                checked_n;
  int                sat_n;
  logic [3:0]        seen_mask;
  bit                leftovers_done;

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("[%0t] mismatch: %s, got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // clamp to q16.16 range, bit 32 flags saturation
  function automatic logic [DATA_W:0] clamp_q(input longint v);
    if (v > Q_HI) return {1'b1, Q_MAX};
    if (v < Q_LO) return {1'b1, Q_MIN};
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  // apply one token to the shadow stack and queue its result
  task automatic evaluate_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] opv);
    token_result_t    res;
    longint           lhs;
    longint           rhs;
    longint           mag_l;
    longint           mag_r;
    longint           raw;
    logic [DATA_W:0]  clamped;
    logic             neg;
    res.status = ST_OK;
    clamped    = '0;
    if (cmd == CMD_PUSH) begin
      if (stack_count >= STACK_DEPTH) begin
        res.status = ST_OVER;
      end else begin
        value_stack[stack_count] = opv;
        stack_count++;
      end
    end else if (cmd <= CMD_DIV) begin
      if (stack_count < 2) begin
        res.status = ST_UNDER;
      end else begin
        rhs   = longint'($signed(value_stack[stack_count-1]));
        lhs   = longint'($signed(value_stack[stack_count-2]));
        mag_l = (lhs < 0) ? -lhs : lhs;
        mag_r = (rhs < 0) ? -rhs : rhs;
        neg   = (lhs < 0) != (rhs < 0);
        if (cmd == CMD_DIV && rhs == 0) begin
          res.status = ST_DIVZERO;
        end else begin
          case (cmd)
            CMD_ADD: raw = lhs + rhs;
            CMD_SUB: raw = lhs - rhs;
            CMD_MUL: raw = (mag_l * mag_r) >> FRAC_W;
            default: raw = (mag_l << FRAC_W) / mag_r;
          endcase
          // multiply and divide work on magnitudes, so truncation is toward zero
          if ((cmd == CMD_MUL || cmd == CMD_DIV) && neg) raw = -raw;
          clamped = clamp_q(raw);
          stack_count--;
          value_stack[stack_count-1] = clamped[DATA_W-1:0];
        end
      end
    end
    res.top_value = (stack_count > 0) ? value_stack[stack_count-1] : '0;
    res.depth     = DEPTH_W'(stack_count);
    res.saturated = clamped[DATA_W];
    predicted_results.push_back(res);
  endtask

  always @(posedge clk) begin
    token_result_t want;
    if (!rst_n) begin
      stack_count    = 0;
      predicted_results.delete();
      mismatches     = 0;
      checked_n      = 0;
      sat_n          = 0;
      seen_mask      = '0;
      leftovers_done = 1'b0;
    end else begin
      // new request first, so the queue stays in order
      if (in_valid && !in_stall) evaluate_token(in_command, in_operand_value);
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing predicted", out_top_value, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
          if (out_top_value !== want.top_value)
            report_mismatch("top value", out_top_value, want.top_value);
          if (out_depth !== want.depth)
            report_mismatch("depth", DATA_W'(out_depth), DATA_W'(want.depth));
          if (out_saturated !== want.saturated)
            report_mismatch("saturated", DATA_W'(out_saturated), DATA_W'(want.saturated));
          checked_n++;
          if (out_saturated === 1'b1) sat_n++;
          seen_mask[out_status] = 1'b1;
        end
      end
      // anything still queued at the end never arrived
      if (end_of_run && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (predicted_results.size() != 0)
          report_mismatch("results never delivered", DATA_W'(predicted_results.size()), '0);
      end
    end
    fail_count      <= mismatches;
    pending         <= predicted_results.size();
    results_checked <= checked_n;
    saturations     <= sat_n;
    status_seen     <= seen_mask;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pse_pkg::*;

  localparam int ITEMS_PER_PHASE = 450;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 80;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic        [CMD_W-1:0]    in_command = CMD_PUSH;
  logic signed [DATA_W-1:0]   in_operand_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0]   out_top_value;
  logic        [DEPTH_W-1:0]  out_depth;
  logic                       out_saturated;

  logic       end_of_run = 1'b0;
  logic       hold_kick = 1'b0;
  bit         hold_used = 1'b0;
  int         hold_left = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;
  int         tokens_counted = 0;
  int         est_depth = 0;
  int         fail_count;
  int         pending;
  int         results_checked;
  int         saturations;
  logic [3:0] status_seen;

  always #10 clk = ~clk;

  postfix_stack_evaluator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_top_value    (out_top_value),
    .out_depth        (out_depth),
    .out_saturated    (out_saturated)
  );

  pse_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_top_value    (out_top_value),
    .out_depth        (out_depth),
    .out_saturated    (out_saturated),
    .end_of_run       (end_of_run),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .saturations      (saturations),
    .status_seen      (status_seen)
  );

  // result side stall, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_kick && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_operand_value <= val;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (cmd <= CMD_DIV) tokens_counted++;
  endtask

  // operands biased toward zero, edge values and small numbers
  function automatic logic [DATA_W-1:0] pick_operand();
    logic [DATA_W-1:0] val;
    case ($urandom_range(9))
      0: val = '0;
      1: begin
        case ($urandom_range(5))
          0: val = Q_MAX;
          1: val = Q_MIN;
          2: val = 32'hFFFF_0000;
          3: val = 32'h0001_0000;
          4: val = 32'hFFFF_FFFF;
          default: val = 32'h0000_0001;
        endcase
      end
      2, 3, 4, 5: begin
        val = DATA_W'($urandom_range(32'h3_FFFF));
        if ($urandom_range(1) != 0) val = -val;
      end
      default: val = $urandom();
    endcase
    return val;
  endfunction

  function automatic logic [CMD_W-1:0] pick_operator(input bit allow_div);
    case ($urandom_range(allow_div ? 3 : 2))
      0: return CMD_ADD;
      1: return CMD_SUB;
      2: return CMD_MUL;
      default: return CMD_DIV;
    endcase
  endfunction

  // random expressions until the token count reaches the target
  task automatic run_expressions(input int target);
    int kind;
    int len;
    while (tokens_counted < target) begin
      kind = $urandom_range(9);
      if (kind < 8) begin
        // well formed: only operators with two entries on the stack
        len = $urandom_range(4, 20);
        repeat (len) begin
          if (est_depth < 2 || (est_depth < STACK_DEPTH && $urandom_range(1) != 0)) begin
            send_token(CMD_PUSH, pick_operand());
            est_depth++;
          end else begin
            send_token(pick_operator(1'b1), $urandom());
            est_depth--;
          end
        end
      end else if (kind == 8) begin
        // fill past the top, then fold it all down and a bit beyond
        while (est_depth < STACK_DEPTH + 2) begin
          send_token(CMD_PUSH, pick_operand());
          est_depth++;
        end
        repeat (STACK_DEPTH + 1) send_token(pick_operator(1'b0), $urandom());
        est_depth = 1;
      end else begin
        // noise: any command code, any value
        repeat ($urandom_range(1, 6)) send_token(CMD_W'($urandom_range(7)), $urandom());
      end
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edge values, errors, every command
    send_token(CMD_ADD, $urandom());
    send_token(CMD_PUSH, Q_MAX);
    send_token(CMD_SUB, $urandom());
    repeat (11) send_token(CMD_PUSH, $urandom());
    send_token(CMD_PUSH, 32'h0003_0000);
    send_token(CMD_PUSH, 32'h0000_0000);
    send_token(CMD_PUSH, Q_MIN);
    send_token(CMD_PUSH, 32'hFFFF_0000);
    send_token(CMD_PUSH, Q_MAX);
    send_token(CMD_DIV, $urandom());
    send_token(CMD_MUL, $urandom());
    send_token(CMD_DIV, $urandom());
    send_token(CMD_SPARE_5, $urandom());
    send_token(CMD_SPARE_7, $urandom());
    send_token(CMD_ADD, $urandom());
    send_token(CMD_PUSH, Q_MAX);
    send_token(CMD_ADD, $urandom());
    est_depth = 13;

    // long result hold-off while requests keep coming
    hold_kick <= 1'b1;
    run_expressions(ITEMS_PER_PHASE);
    wait_for_results();

    idle_pct <= 71;
    run_expressions(2 * ITEMS_PER_PHASE);
    wait_for_results();

    idle_pct  <= 0;
    stall_pct <= 71;
    run_expressions(3 * ITEMS_PER_PHASE);
    wait_for_results();

    idle_pct  <= 36;
    stall_pct <= 36;
    run_expressions(4 * ITEMS_PER_PHASE);
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d tokens over four handshake phases, %0d results checked",
             tokens_counted, results_checked);
    $display("saturated results %0d, status codes seen %b", saturations, status_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/pse_arith.sv
rtl/postfix_stack_evaluator.sv
tb/pse_checker.sv
tb/tb_top.sv
